// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define EGR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define EGR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/egr_pkg.sv =====
// types and codes of the exp-golomb and rice encoder
`timescale 1ns / 1ps
package egr_pkg;

  typedef enum logic [1:0] {
    CMD_UE   = 2'd0,
    CMD_SE   = 2'd1,
    CMD_RICE = 2'd2,
    CMD_RSVD = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_INVALID  = 2'd1,
    ST_TOO_LONG = 2'd2
  } status_t;

  localparam int unsigned CodeW  = 64;
  localparam int unsigned LenW   = 7;
  localparam int unsigned ValueW = 32;
  localparam int unsigned KW     = 4;

  typedef struct packed {
    cmd_t                      command;
    logic signed [ValueW-1:0]  value;
    logic [KW-1:0]             rice_k;
  } in_item_t;

  typedef struct packed {
    logic [CodeW-1:0] code_bits;
    logic [LenW-1:0]  code_length;
    status_t          status;
  } out_item_t;

endpackage

// ===== hw/rtl/egr_in_if.sv =====
// input channel: command, value and rice parameter with valid/ready
`timescale 1ns / 1ps
interface egr_in_if;
  import egr_pkg::*;

  logic                     valid;
  logic                     ready;
  cmd_t                     command;
  logic signed [ValueW-1:0] value;
  logic [KW-1:0]            rice_k;

  modport source (output valid, output command, output value, output rice_k, input ready);
  modport sink   (input valid, input command, input value, input rice_k, output ready);
endinterface

// ===== hw/rtl/egr_out_if.sv =====
// result channel: codeword, length and status with valid/ready
`timescale 1ns / 1ps
interface egr_out_if;
  import egr_pkg::*;

  logic             valid;
  logic             ready;
  logic [CodeW-1:0] code_bits;
  logic [LenW-1:0]  code_length;
  status_t          status;

  modport source (output valid, output code_bits, output code_length, output status,
                  input ready);
  modport sink   (input valid, input code_bits, input code_length, input status,
                  output ready);
endinterface

// ===== hw/rtl/egr_lod.sv =====
// leading-one detect over the 33-bit exp-golomb code number plus one
`timescale 1ns / 1ps
module egr_lod (
  input  logic [32:0] x,
  output logic [5:0]  msb
);
  always_comb begin
    msb = '0;
    for (int i = 0; i < 33; i++) begin
      if (x[i]) begin
        msb = 6'(i);
      end
    end
  end
endmodule

// ===== hw/rtl/egr_encode.sv =====
// combinational codeword builder for one registered item
`timescale 1ns / 1ps
module egr_encode (
  input  egr_pkg::in_item_t  item,
  output egr_pkg::out_item_t res
);
  import egr_pkg::*;

  logic        neg;
  logic [32:0] ext;
  logic [32:0] mag;
  logic [32:0] mag2;
  logic [32:0] n_se;
  logic [32:0] n_eg;
  logic [32:0] x_eg;
  logic [5:0]  l_eg;
  logic [31:0] m_rice;
  logic [31:0] prefix;
  logic [31:0] mask;
  logic [15:0] rice_code;
  logic [7:0]  rice_len;
  logic        rice_long;

  assign neg  = item.value[31];
  assign ext  = {item.value[31], item.value};
  assign mag  = neg ? (~ext + 33'd1) : ext;
  assign mag2 = {mag[31:0], 1'b0};

  // signed mapping: positive to 2v-1, non-positive to -2v
  assign n_se = (neg || mag == '0) ? mag2 : (mag2 - 33'd1);
  assign n_eg = (item.command == CMD_SE) ? n_se : {1'b0, item.value};
  assign x_eg = n_eg + 33'd1;

  egr_lod u_lod (
    .x   (x_eg),
    .msb (l_eg)
  );

  // rice level mapping: positive to 2(v-1), negative to -2v-1
  assign m_rice    = neg ? (mag2[31:0] - 32'd1) : {mag[30:0] - 31'd1, 1'b0};
  assign prefix    = m_rice >> item.rice_k;
  assign mask      = (32'd1 << item.rice_k) - 32'd1;
  assign rice_code = (16'd1 << item.rice_k) | 16'(m_rice & mask);
  assign rice_len  = 8'(prefix[5:0]) + 8'd1 + 8'(item.rice_k);
  assign rice_long = (|prefix[31:6]) || (rice_len > 8'd64);

  always_comb begin
    res.code_bits   = '0;
    res.code_length = '0;
    res.status      = ST_INVALID;
    unique case (item.command) inside
      CMD_UE, CMD_SE: begin
        if (item.command == CMD_UE && neg) begin
          res.status = ST_INVALID;
        end else if (x_eg[32]) begin
          res.status = ST_TOO_LONG;
        end else begin
          res.code_bits   = {31'd0, x_eg};
          res.code_length = {l_eg, 1'b1};
          res.status      = ST_OK;
        end
      end
      CMD_RICE: begin
        if (mag == '0) begin
          res.status = ST_INVALID;
        end else if (rice_long) begin
          res.status = ST_TOO_LONG;
        end else begin
          res.code_bits   = {48'd0, rice_code};
          res.code_length = rice_len[6:0];
          res.status      = ST_OK;
        end
      end
      default: begin
        res.status = ST_INVALID;
      end
    endcase
  end
endmodule

// ===== hw/rtl/exp_golomb_and_rice_encoder.sv =====
// top level: exp-golomb (ue/se) and golomb-rice codeword encoder
// path: an accepted item is held in the input register, then in the result register
// throughput: one item per cycle; a new item is taken every cycle while results drain
// the logic between the registers is egr_encode, with a 33-bit leading-one detect and a 32-bit shifter
// reset: synchronous, active low; clears both valid flags, payload registers are not reset
`timescale 1ns / 1ps
`include "assert_macros.svh"
module exp_golomb_and_rice_encoder (
  input logic      clk,
  input logic      rst_n,
  egr_in_if.sink   in_ch,
  egr_out_if.source out_ch
);
  import egr_pkg::*;

  // stage 1: registered input item
  logic      s1_valid_r;
  logic      s1_valid_nxt;
  in_item_t  s1_item_r;
  logic      s1_ready;

  // stage 2: registered result
  logic      out_valid_r;
  logic      out_valid_nxt;
  out_item_t out_item_r;
  out_item_t enc_res;

  logic      in_xfer;

  // result register frees when empty or when its transfer happens this cycle
  assign s1_ready    = !out_valid_r || out_ch.ready;
  // input register frees when empty or when it moves into the result register
  assign in_ch.ready = !s1_valid_r || s1_ready;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  assign s1_valid_nxt  = in_ch.ready ? in_ch.valid : s1_valid_r;
  assign out_valid_nxt = s1_ready ? s1_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload capture, no reset needed
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_item_r.command <= in_ch.command;
      s1_item_r.value   <= in_ch.value;
      s1_item_r.rice_k  <= in_ch.rice_k;
    end
    if (s1_valid_r && s1_ready) begin
      out_item_r <= enc_res;
    end
  end

  // codeword logic between the two registers
  egr_encode u_encode (
    .item (s1_item_r),
    .res  (enc_res)
  );

  assign out_ch.valid       = out_valid_r;
  assign out_ch.code_bits   = out_item_r.code_bits;
  assign out_ch.code_length = out_item_r.code_length;
  assign out_ch.status      = out_item_r.status;

  // a failed code carries no bits and no length
  `EGR_ASSERT_IMP(a_fail_empty, out_valid_r && out_item_r.status != ST_OK, out_item_r.code_bits == '0 && out_item_r.code_length == '0, "failed code not cleared")
  // a good code has a length of 1 to 64 and nothing above it
  `EGR_ASSERT_IMP(a_ok_fits, out_valid_r && out_item_r.status == ST_OK, out_item_r.code_length != '0 && out_item_r.code_length <= 7'd64 && (out_item_r.code_bits >> out_item_r.code_length) == '0, "code exceeds its length")
  // an item leaving stage 1 shows up as a result next cycle
  `EGR_ASSERT_NEXT(a_s1_to_out, s1_valid_r && s1_ready, out_valid_r, "stage 1 item lost")

endmodule

// ===== tb/tb.sv =====
// testbench for the exp-golomb and golomb-rice codeword encoder
`timescale 1ns / 1ps
module tb;
  import egr_pkg::*;

  // run guard, far above the slowest correct run with these gap and stall rates
  localparam int unsigned CycleLimit   = 300000;
  localparam int unsigned DrainCycles  = 10;
  localparam int unsigned ReportLimit  = 10;
  localparam int unsigned PhaseItems   = 250;

  logic clk;
  logic rst_n;

  egr_in_if  in_ch ();
  egr_out_if out_ch ();

  exp_golomb_and_rice_encoder u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // codewords predicted for accepted requests, oldest first
  out_item_t   expected_codewords[$];
  int unsigned mismatch_count;
  int unsigned cycle_count;

  // idle rates in percent, changed per phase
  int unsigned gap_pct;
  int unsigned stall_pct;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // expected codeword for one request
  function automatic out_item_t predict_codeword(in_item_t req);
    out_item_t   res;
    logic        neg;
    logic [63:0] mag;
    logic [63:0] num;
    logic [63:0] plus1;
    logic [63:0] lvl;
    logic [63:0] quot;
    logic [63:0] len;
    int unsigned lead;
    res.code_bits   = '0;
    res.code_length = '0;
    res.status      = ST_INVALID;
    neg = req.value[ValueW-1];
    // magnitude 0 .. 2^31, one bit wider than the value
    mag = neg ? (64'h1_0000_0000 - {32'd0, req.value}) : {32'd0, req.value};
    case (req.command) inside
      CMD_UE, CMD_SE: begin
        if (req.command == CMD_UE) begin
          if (neg) return res;
          num = mag;
        end else if (neg || mag == 64'd0) begin
          num = 2 * mag;
        end else begin
          num = 2 * mag - 1;
        end
        plus1 = num + 1;
        lead  = 0;
        for (int i = 0; i < 64; i++) begin
          if (plus1[i]) lead = i;
        end
        if (2 * lead + 1 > CodeW) begin
          res.status = ST_TOO_LONG;
        end else begin
          res.code_bits   = plus1;
          res.code_length = LenW'(2 * lead + 1);
          res.status      = ST_OK;
        end
      end
      CMD_RICE: begin
        if (mag == 64'd0) return res;
        lvl  = neg ? (2 * mag - 1) : (2 * (mag - 1));
        quot = lvl >> req.rice_k;
        len  = quot + 1 + req.rice_k;
        if (len > CodeW) begin
          res.status = ST_TOO_LONG;
        end else begin
          res.code_bits   = (64'd1 << req.rice_k) | (lvl & ((64'd1 << req.rice_k) - 1));
          res.code_length = len[LenW-1:0];
          res.status      = ST_OK;
        end
      end
      default: return res;
    endcase
    return res;
  endfunction

  // one request transfer; valid stays high afterwards unless the next call idles first
  task automatic send_request(cmd_t cmd, logic signed [31:0] val, logic [3:0] k);
    in_item_t req;
    req.command = cmd;
    req.value   = val;
    req.rice_k  = k;
    while ($urandom_range(0, 99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.command <= req.command;
    in_ch.value   <= req.value;
    in_ch.rice_k  <= req.rice_k;
    do @(posedge clk); while (!in_ch.ready);
    expected_codewords.push_back(predict_codeword(req));
  endtask

  // receiver: random stalls and comparison of each result transfer
  initial begin
    out_item_t want;
    out_item_t got;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got.code_bits   = out_ch.code_bits;
        got.code_length = out_ch.code_length;
        got.status      = out_ch.status;
        if (expected_codewords.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= ReportLimit)
            $display("mismatch: codeword with none expected: bits %h len %0d status %0d",
                     got.code_bits, got.code_length, got.status);
        end else begin
          want = expected_codewords.pop_front();
          if (got.code_bits !== want.code_bits || got.code_length !== want.code_length ||
              got.status !== want.status) begin
            mismatch_count++;
            if (mismatch_count <= ReportLimit)
              $display({"mismatch: expected bits %h len %0d status %0d, ",
                        "got bits %h len %0d status %0d"},
                       want.code_bits, want.code_length, want.status,
                       got.code_bits, got.code_length, got.status);
          end
        end
      end
      out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // hang guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ue: zero, small values, powers of two around the prefix steps, largest value, negatives
  task automatic test_ue_codes();
    send_request(CMD_UE, 32'sd0, 4'd0);
    send_request(CMD_UE, 32'sd1, 4'd0);
    send_request(CMD_UE, 32'sd2, 4'd0);
    send_request(CMD_UE, 32'sd7, 4'd0);
    send_request(CMD_UE, 32'sh7fff_ffff, 4'd15);
    send_request(CMD_UE, -32'sd1, 4'd0);
    send_request(CMD_UE, 32'sh8000_0000, 4'd0);
  endtask

  // se: both signs, extremes, and the most negative value that overflows the codeword
  task automatic test_se_codes();
    send_request(CMD_SE, 32'sd0, 4'd0);
    send_request(CMD_SE, 32'sd1, 4'd0);
    send_request(CMD_SE, -32'sd1, 4'd0);
    send_request(CMD_SE, 32'sh7fff_ffff, 4'd0);
    send_request(CMD_SE, 32'sh8000_0001, 4'd0);
    send_request(CMD_SE, 32'sh8000_0000, 4'd0);
  endtask

  // rice: zero level, both signs, widest suffix, codeword of exactly 64 bits and one over
  task automatic test_rice_codes();
    send_request(CMD_RICE, 32'sd0, 4'd3);
    send_request(CMD_RICE, 32'sd1, 4'd0);
    send_request(CMD_RICE, -32'sd1, 4'd0);
    send_request(CMD_RICE, 32'sd1, 4'd15);
    send_request(CMD_RICE, -32'sd32, 4'd0);
    send_request(CMD_RICE, 32'sd33, 4'd0);
    send_request(CMD_RICE, 32'sh7fff_ffff, 4'd15);
    send_request(CMD_RICE, 32'sh8000_0000, 4'd0);
  endtask

  // unused command code always reports an invalid value
  task automatic test_reserved_command();
    send_request(CMD_RSVD, 32'sd5, 4'd2);
    send_request(CMD_RSVD, 32'sh8000_0000, 4'd15);
  endtask

  function automatic logic signed [31:0] random_value();
    logic signed [31:0] v;
    case ($urandom_range(0, 3))
      0: v = $urandom;
      1: v = $signed(32'($urandom_range(0, 40))) - 32'sd20;
      2: begin
        v = $urandom >> $urandom_range(0, 31);
        if ($urandom_range(0, 1)) v = -v;
      end
      default: begin
        case ($urandom_range(0, 4))
          0: v = 32'sd0;
          1: v = 32'sd1;
          2: v = -32'sd1;
          3: v = 32'sh7fff_ffff;
          default: v = 32'sh8000_0000;
        endcase
      end
    endcase
    return v;
  endfunction

  // random mix of all commands; rice levels mostly sized so the codeword fits
  task automatic test_random_mix(int unsigned count, int unsigned gap, int unsigned stall);
    cmd_t               cmd;
    logic signed [31:0] val;
    logic [3:0]         k;
    int unsigned        sel;
    int unsigned        mag;
    gap_pct   = gap;
    stall_pct = stall;
    repeat (count) begin
      sel = $urandom_range(0, 9);
      k   = 4'($urandom);
      val = random_value();
      if (sel < 3) begin
        cmd = CMD_UE;
        if ($urandom_range(0, 3) != 0) val[31] = 1'b0;
      end else if (sel < 6) begin
        cmd = CMD_SE;
      end else if (sel < 9) begin
        cmd = CMD_RICE;
        if ($urandom_range(0, 4) != 0) begin
          mag = $urandom_range(1, 40 << k);
          val = $urandom_range(0, 1) ? -$signed(32'(mag)) : $signed(32'(mag));
        end
      end else begin
        cmd = CMD_RSVD;
      end
      send_request(cmd, val, k);
    end
  endtask

  initial begin
    mismatch_count = 0;
    cycle_count    = 0;
    gap_pct        = 0;
    stall_pct      = 0;
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.command <= CMD_UE;
    in_ch.value   <= '0;
    in_ch.rice_k  <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part at full rate, then random phases with varying input gaps and back pressure
    test_ue_codes();
    test_se_codes();
    test_rice_codes();
    test_reserved_command();
    test_random_mix(PhaseItems, 0, 0);
    test_random_mix(PhaseItems, 68, 0);
    test_random_mix(PhaseItems, 0, 68);
    test_random_mix(PhaseItems, 11, 11);
    in_ch.valid <= 1'b0;

    // drain, then wait DrainCycles more to catch any extra codeword
    while (expected_codewords.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (mismatch_count == 0 && expected_codewords.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/egr_pkg.sv
hw/rtl/egr_in_if.sv
hw/rtl/egr_out_if.sv
hw/rtl/egr_lod.sv
hw/rtl/egr_encode.sv
hw/rtl/exp_golomb_and_rice_encoder.sv
tb/tb.sv
